>>> sv/tch_pkg.sv
// Shared types, constants and tables for the tilt-compensated heading core.
package tch_pkg;

   // Field widths
   localparam int DATA_W = 16;
   localparam int HEAD_W = 17;
   localparam int DECL_W = 15;

   // Angle format and CORDIC depth
   localparam int ANGLE_FRAC_BITS  = 6;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_MAX       = 24;
   localparam int TAB_BITS         = 16;

   // Square root: 64-bit radicand, one result bit a step, two steps a stage
   localparam int SQ_STEPS = 32;
   localparam int SQ_REM_W = 36;
   localparam int SQ_ROOT_W = 32;

   // CORDIC datapath widths
   localparam int NORM_W = 30;
   localparam int C_W    = 33;
   localparam int Z_W    = 25;
   localparam int TAB_W  = 22;

   // Square root working set
   typedef struct packed {
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_ROOT_W-1:0] root;
      logic [63:0]          rad;
   } sq_type;

   // atan2 arguments, both scaled by the same positive factor
   typedef struct packed {
      logic signed [63:0] y;
      logic signed [63:0] x;
   } vec_res_type;

   // Normalised magnitudes and the quadrant flags
   typedef struct packed {
      logic [NORM_W-1:0] cx;
      logic [NORM_W-1:0] cy;
      logic              xneg;
      logic              yneg;
      logic              zero;
   } norm_res_type;

   // One restoring square-root step
   function automatic sq_type sq_step(input sq_type s);
      logic [SQ_REM_W-1:0] rem2;
      logic [SQ_REM_W-1:0] trial;
      sq_type r;
      rem2  = {s.rem[SQ_REM_W-3:0], s.rad[63:62]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[61:0], 2'b00};
      if (rem2 >= trial) begin
         r.rem  = rem2 - trial;
         r.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = rem2;
         r.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // Arctangent of 2^-i in 2^-16 degree units
   function automatic logic [TAB_W-1:0] atan_tab(input int i);
      logic [TAB_W-1:0] v;
      unique case (i)
         0:  v = 22'd2949120;
         1:  v = 22'd1740967;
         2:  v = 22'd919879;
         3:  v = 22'd466945;
         4:  v = 22'd234379;
         5:  v = 22'd117304;
         6:  v = 22'd58666;
         7:  v = 22'd29335;
         8:  v = 22'd14668;
         9:  v = 22'd7334;
         10: v = 22'd3667;
         11: v = 22'd1833;
         12: v = 22'd917;
         13: v = 22'd458;
         14: v = 22'd229;
         15: v = 22'd115;
         16: v = 22'd57;
         17: v = 22'd29;
         18: v = 22'd14;
         19: v = 22'd7;
         20: v = 22'd4;
         21: v = 22'd2;
         22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

>>> sv/tch_req_if.sv
// Input channel: magnetometer and gravity vectors with valid/ready.
interface tch_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tch_pkg::DATA_W-1:0]    mag_x;
   logic signed [tch_pkg::DATA_W-1:0]    mag_y;
   logic signed [tch_pkg::DATA_W-1:0]    mag_z;
   logic signed [tch_pkg::DATA_W-1:0]    grav_x;
   logic signed [tch_pkg::DATA_W-1:0]    grav_y;
   logic signed [tch_pkg::DATA_W-1:0]    grav_z;

   modport source (output valid, mag_x, mag_y, mag_z, grav_x, grav_y, grav_z,
                   input ready);
   modport sink (input valid, mag_x, mag_y, mag_z, grav_x, grav_y, grav_z,
                 output ready);
endinterface

>>> sv/tch_rsp_if.sv
// Result channel: heading with valid/ready.
interface tch_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [tch_pkg::HEAD_W-1:0] heading;

   modport source (output valid, heading, input ready);
   modport sink (input valid, heading, output ready);
endinterface

>>> sv/tch_vec.sv
// Front end: products, two pipelined square roots and the atan2 arguments.
module tch_vec (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [tch_pkg::DATA_W-1:0] mag_x,
   input  logic signed [tch_pkg::DATA_W-1:0] mag_y,
   input  logic signed [tch_pkg::DATA_W-1:0] mag_z,
   input  logic signed [tch_pkg::DATA_W-1:0] grav_x,
   input  logic signed [tch_pkg::DATA_W-1:0] grav_y,
   input  logic signed [tch_pkg::DATA_W-1:0] grav_z,
   output logic                              out_valid,
   input  logic                              out_ready,
   output tch_pkg::vec_res_type              out_data
);
   import tch_pkg::*;

   localparam int SQ_STG = SQ_STEPS / 2;
   localparam int N_STG  = SQ_STG + 3;
   localparam int P1     = SQ_STG + 1;
   localparam int P2     = SQ_STG + 2;

   // Carried alongside the square roots
   typedef struct packed {
      logic signed [32:0] a;
      logic signed [32:0] b;
      logic signed [31:0] mxtz;
      logic signed [15:0] tx;
   } car_type;

   logic [N_STG-1:0] vld_ff;
   logic [N_STG-1:0] adv;

   // Entry stage
   logic signed [15:0] py, pz;
   logic signed [16:0] gz17, tz;
   logic [31:0]        sp_in, st_in, sp_ff, st_ff;
   logic signed [31:0] mzpy_in, mypz_in, mzpz_in, mypy_in, mxtz_in;
   logic signed [31:0] mzpy_ff, mypz_ff, mzpz_ff, mypy_ff, mxtz_ff;
   logic signed [15:0] tx_ff;

   // Square root stages
   sq_type  sqp_in [SQ_STG];
   sq_type  sqt_in [SQ_STG];
   sq_type  sqp_ff [SQ_STG];
   sq_type  sqt_ff [SQ_STG];
   car_type car_in [SQ_STG];
   car_type car_ff [SQ_STG];

   // Product stages
   logic signed [63:0] y_in, y_ff, xa_in, xa_ff, x_in, x_ff, y2_ff;
   logic signed [48:0] xb_in, xb_ff;
   logic [30:0]        rp, rt;

   // Stall chain: a stage moves when empty or when the next one moves
   always_comb begin
      adv[N_STG-1] = !vld_ff[N_STG-1] || out_ready;
      for (int k = N_STG - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end
   assign in_ready  = adv[0];
   assign out_valid = vld_ff[N_STG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < N_STG; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Entry: degenerate gravity fixes, squares and cross products
   always_comb begin
      py   = grav_y;
      pz   = (grav_y == 16'sd0 && grav_z == 16'sd0) ? 16'sd1 : grav_z;
      gz17 = 17'(grav_z);
      tz   = (gz17 < 17'sd0) ? -gz17 : gz17;
      if (grav_x == 16'sd0 && grav_z == 16'sd0) tz = 17'sd1;
      sp_in   = 32'(33'(py) * 33'(py) + 33'(pz) * 33'(pz));
      st_in   = 32'(34'(grav_x) * 34'(grav_x) + 34'(tz) * 34'(tz));
      mzpy_in = 32'(mag_z) * 32'(py);
      mypz_in = 32'(mag_y) * 32'(pz);
      mzpz_in = 32'(mag_z) * 32'(pz);
      mypy_in = 32'(mag_y) * 32'(py);
      mxtz_in = 32'(34'(mag_x) * 34'(tz));
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sp_ff   <= sp_in;
         st_ff   <= st_in;
         mzpy_ff <= mzpy_in;
         mypz_ff <= mypz_in;
         mzpz_ff <= mzpz_in;
         mypy_ff <= mypy_in;
         mxtz_ff <= mxtz_in;
         tx_ff   <= grav_x;
      end
   end

   // Square roots, two result bits a stage
   always_comb begin
      sq_type p0, t0;
      p0.rem  = '0;
      p0.root = '0;
      p0.rad  = {2'b00, sp_ff, 30'd0};
      t0.rem  = '0;
      t0.root = '0;
      t0.rad  = {2'b00, st_ff, 30'd0};
      sqp_in[0]      = sq_step(sq_step(p0));
      sqt_in[0]      = sq_step(sq_step(t0));
      car_in[0].a    = 33'(mzpy_ff) + 33'(mypz_ff);
      car_in[0].b    = 33'(mzpz_ff) - 33'(mypy_ff);
      car_in[0].mxtz = mxtz_ff;
      car_in[0].tx   = tx_ff;
      for (int j = 1; j < SQ_STG; j++) begin
         sqp_in[j] = sq_step(sq_step(sqp_ff[j-1]));
         sqt_in[j] = sq_step(sq_step(sqt_ff[j-1]));
         car_in[j] = car_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < SQ_STG; j++) begin
         if (adv[j+1]) begin
            sqp_ff[j] <= sqp_in[j];
            sqt_ff[j] <= sqt_in[j];
            car_ff[j] <= car_in[j];
         end
      end
   end

   // Scale by the roots, then assemble X
   assign rp = sqp_ff[SQ_STG-1].root[30:0];
   assign rt = sqt_ff[SQ_STG-1].root[30:0];

   always_comb begin
      y_in  = 64'(car_ff[SQ_STG-1].a) * 64'($signed({1'b0, rt}));
      xa_in = 64'(car_ff[SQ_STG-1].mxtz) * 64'($signed({1'b0, rp}));
      xb_in = 49'(car_ff[SQ_STG-1].tx) * 49'(car_ff[SQ_STG-1].b);
      x_in  = xa_ff + (64'(xb_ff) <<< 15);
   end

   always_ff @(posedge clock) begin
      if (adv[P1]) begin
         y_ff  <= y_in;
         xa_ff <= xa_in;
         xb_ff <= xb_in;
      end
      if (adv[P2]) begin
         y2_ff <= y_ff;
         x_ff  <= x_in;
      end
   end

   assign out_data.y = y2_ff;
   assign out_data.x = x_ff;

endmodule

>>> sv/tch_norm.sv
// Magnitudes, quadrant flags and common power-of-two normalisation.
module tch_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tch_pkg::vec_res_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tch_pkg::norm_res_type out_data
);
   import tch_pkg::*;

   localparam int N_STG = 3;

   logic [N_STG-1:0] vld_ff;
   logic [N_STG-1:0] adv;

   logic [62:0] ax_ff [N_STG];
   logic [62:0] ay_ff [N_STG];
   logic        xneg_ff [N_STG];
   logic        yneg_ff [N_STG];
   logic        zero_ff [N_STG];

   logic [63:0]  negx, negy;
   logic [125:0] s1, s2;

   // Left shift both by n when the top n bits of both are clear
   function automatic logic [125:0] norm_step(input logic [125:0] p, input int n);
      logic [62:0] a, b;
      a = p[125:63];
      b = p[62:0];
      if (((a | b) >> (63 - n)) == 63'd0) begin
         a = a << n;
         b = b << n;
      end
      return {a, b};
   endfunction

   always_comb begin
      adv[N_STG-1] = !vld_ff[N_STG-1] || out_ready;
      for (int k = N_STG - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end
   assign in_ready  = adv[0];
   assign out_valid = vld_ff[N_STG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < N_STG; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Leading one goes to bit 62 in six binary steps
   always_comb begin
      negx = -in_data.x;
      negy = -in_data.y;
      s1   = norm_step(norm_step(norm_step({ax_ff[0], ay_ff[0]}, 32), 16), 8);
      s2   = norm_step(norm_step(norm_step({ax_ff[1], ay_ff[1]}, 4), 2), 1);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ax_ff[0]   <= in_data.x[63] ? negx[62:0] : in_data.x[62:0];
         ay_ff[0]   <= in_data.y[63] ? negy[62:0] : in_data.y[62:0];
         xneg_ff[0] <= in_data.x[63];
         yneg_ff[0] <= in_data.y[63];
         zero_ff[0] <= (in_data.x == 64'sd0) && (in_data.y == 64'sd0);
      end
      if (adv[1]) begin
         ax_ff[1]   <= s1[125:63];
         ay_ff[1]   <= s1[62:0];
         xneg_ff[1] <= xneg_ff[0];
         yneg_ff[1] <= yneg_ff[0];
         zero_ff[1] <= zero_ff[0];
      end
      if (adv[2]) begin
         ax_ff[2]   <= s2[125:63];
         ay_ff[2]   <= s2[62:0];
         xneg_ff[2] <= xneg_ff[1];
         yneg_ff[2] <= yneg_ff[1];
         zero_ff[2] <= zero_ff[1];
      end
   end

   // Larger magnitude lands in [2^29, 2^30)
   assign out_data.cx   = ax_ff[2][62:33];
   assign out_data.cy   = ay_ff[2][62:33];
   assign out_data.xneg = xneg_ff[2];
   assign out_data.yneg = yneg_ff[2];
   assign out_data.zero = zero_ff[2];

endmodule

>>> sv/tch_cordic.sv
// CORDIC vectoring stages, rounding, quadrant and declination.
module tch_cordic #(
   parameter int CORDIC_STEPS = tch_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  tch_pkg::norm_res_type             in_data,
   input  logic signed [tch_pkg::DECL_W-1:0] decl,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [tch_pkg::HEAD_W-1:0] heading
);
   import tch_pkg::*;

   localparam int N_STG = CORDIC_STEPS + 1;
   localparam int LAST  = CORDIC_STEPS - 1;
   localparam int RSH   = TAB_BITS - ANGLE_FRAC_BITS;
   localparam logic signed [Z_W-1:0] Z_MAX = Z_W'(90 * (2 ** TAB_BITS));
   localparam logic [23:0] RND  = 24'(2 ** (RSH - 1));
   localparam logic signed [23:0] HALF = 24'(180 * (2 ** ANGLE_FRAC_BITS));
   localparam logic signed [23:0] H_MAX = 24'sd65535;
   localparam logic signed [23:0] H_MIN = -24'sd65536;

   logic [N_STG-1:0] vld_ff;
   logic [N_STG-1:0] adv;

   logic signed [C_W-1:0] cx_in [CORDIC_STEPS];
   logic signed [C_W-1:0] cy_in [CORDIC_STEPS];
   logic signed [Z_W-1:0] z_in  [CORDIC_STEPS];
   logic signed [C_W-1:0] cx_ff [CORDIC_STEPS];
   logic signed [C_W-1:0] cy_ff [CORDIC_STEPS];
   logic signed [Z_W-1:0] z_ff  [CORDIC_STEPS];
   logic xneg_ff [CORDIC_STEPS];
   logic yneg_ff [CORDIC_STEPS];
   logic zero_ff [CORDIC_STEPS];

   logic [22:0]            zc;
   logic [23:0]            rnd;
   logic signed [23:0]     ang, full, res, h;
   logic signed [HEAD_W-1:0] heading_in, heading_ff;

   always_comb begin
      adv[N_STG-1] = !vld_ff[N_STG-1] || out_ready;
      for (int k = N_STG - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end
   assign in_ready  = adv[0];
   assign out_valid = vld_ff[N_STG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < N_STG; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // One micro-rotation a stage; shifts round toward minus infinity
   always_comb begin
      logic signed [C_W-1:0] sx, sy;
      logic signed [Z_W-1:0] sz, t;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (i == 0) begin
            sx = $signed({3'b000, in_data.cx});
            sy = $signed({3'b000, in_data.cy});
            sz = '0;
         end else begin
            sx = cx_ff[(i == 0) ? 0 : i - 1];
            sy = cy_ff[(i == 0) ? 0 : i - 1];
            sz = z_ff[(i == 0) ? 0 : i - 1];
         end
         t = $signed({3'b000, atan_tab(i)});
         if (!sy[C_W-1]) begin
            cx_in[i] = sx + (sy >>> i);
            cy_in[i] = sy - (sx >>> i);
            z_in[i]  = sz + t;
         end else begin
            cx_in[i] = sx - (sy >>> i);
            cy_in[i] = sy + (sx >>> i);
            z_in[i]  = sz - t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cx_ff[0]   <= cx_in[0];
         cy_ff[0]   <= cy_in[0];
         z_ff[0]    <= z_in[0];
         xneg_ff[0] <= in_data.xneg;
         yneg_ff[0] <= in_data.yneg;
         zero_ff[0] <= in_data.zero;
      end
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         if (adv[i]) begin
            cx_ff[i]   <= cx_in[i];
            cy_ff[i]   <= cy_in[i];
            z_ff[i]    <= z_in[i];
            xneg_ff[i] <= xneg_ff[i-1];
            yneg_ff[i] <= yneg_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
         end
      end
   end

   // Clamp to a quarter turn, round, unfold quadrant, subtract declination, saturate
   always_comb begin
      if (z_ff[LAST] < 0) zc = '0;
      else if (z_ff[LAST] > Z_MAX) zc = Z_MAX[22:0];
      else zc = z_ff[LAST][22:0];
      rnd  = {1'b0, zc} + RND;
      ang  = $signed(rnd >> RSH);
      full = xneg_ff[LAST] ? (HALF - ang) : ang;
      res  = zero_ff[LAST] ? 24'sd0 : (yneg_ff[LAST] ? -full : full);
      h    = res - 24'(decl);
      if (h > H_MAX) heading_in = H_MAX[HEAD_W-1:0];
      else if (h < H_MIN) heading_in = H_MIN[HEAD_W-1:0];
      else heading_in = h[HEAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[N_STG-1]) heading_ff <= heading_in;
   end

   assign heading = heading_ff;

endmodule

>>> sv/tilt_compensated_heading_core.sv
// Top level of the tilt-compensated compass heading pipeline.
// Takes one magnetometer/gravity vector pair per clock unless backpressure holds the pipeline, and
// returns one heading word per pair, in order, in 1/64 degree units less the declination register,
// not wrapped. The pipeline has one entry stage, sixteen square-root stages of two result bits
// each, two multiply stages, three normalisation stages, one CORDIC stage per micro-rotation and
// a final rounding stage. Every stage holds its word under backpressure, so empty stages keep
// filling while a result waits. The declination register resets to zero and should be written
// only while the pipeline is empty.
module tilt_compensated_heading_core #(
   parameter int CORDIC_STEPS = tch_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   tch_req_if.sink                           req_chan,
   tch_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic signed [tch_pkg::DECL_W-1:0] csr_wdata
);
   import tch_pkg::*;

   logic signed [DECL_W-1:0] declination_ff, declination_in;

   logic         vec_vld, vec_rdy;
   vec_res_type  vec_dat;
   logic         nrm_vld, nrm_rdy;
   norm_res_type nrm_dat;

   // Declination register
   assign declination_in = csr_we ? csr_wdata : declination_ff;

   always_ff @(posedge clock) begin
      if (reset) declination_ff <= '0;
      else declination_ff <= declination_in;
   end

   tch_vec u_vec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .mag_x     (req_chan.mag_x),
      .mag_y     (req_chan.mag_y),
      .mag_z     (req_chan.mag_z),
      .grav_x    (req_chan.grav_x),
      .grav_y    (req_chan.grav_y),
      .grav_z    (req_chan.grav_z),
      .out_valid (vec_vld),
      .out_ready (vec_rdy),
      .out_data  (vec_dat)
   );

   tch_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vec_vld),
      .in_ready  (vec_rdy),
      .in_data   (vec_dat),
      .out_valid (nrm_vld),
      .out_ready (nrm_rdy),
      .out_data  (nrm_dat)
   );

   tch_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (nrm_vld),
      .in_ready  (nrm_rdy),
      .in_data   (nrm_dat),
      .decl      (declination_ff),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .heading   (rsp_chan.heading)
   );

   // Input stalls only when the whole pipeline is backed up behind the output
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("input stalled without output backpressure");

   // Words held between front end and normaliser stay put
   a_vec_hold: assert property (@(posedge clock) disable iff (reset)
      (vec_vld && !vec_rdy) |=> (vec_vld && $stable(vec_dat)))
      else $error("front end word changed while stalled");

   // Words held between normaliser and CORDIC stay put
   a_nrm_hold: assert property (@(posedge clock) disable iff (reset)
      (nrm_vld && !nrm_rdy) |=> (nrm_vld && $stable(nrm_dat)))
      else $error("normaliser word changed while stalled");

endmodule
